// ===== sv/ddc_pkg.sv =====
// ----------------------------------------------------------------------------
// ddc_pkg
// Shared constants and types for the distinct day counter.
// ----------------------------------------------------------------------------
package ddc_pkg;

    localparam int GAME_W          = 32;
    localparam int TIME_W          = 32;
    localparam int DAY_W           = 16;
    localparam int DAYS_OUT_W      = 8;
    localparam int TABLE_DEPTH_DEF = 128;

    // t / 86400 == (t >> 7) / 675
    localparam int SECONDS_PER_DAY = 86400;
    localparam int DAY_SHIFT       = 7;
    localparam int DAY_ODD         = SECONDS_PER_DAY >> DAY_SHIFT;
    localparam int QUO_W           = TIME_W - DAY_SHIFT;
    localparam int RECIP_SHIFT     = 35;
    localparam int RECIP_W         = 26;
    localparam logic [RECIP_W-1:0] DAY_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / DAY_ODD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_INSERT,
        S_EMIT
    } t_state;

endpackage

// ===== sv/distinct_day_counter_core.sv =====
// ----------------------------------------------------------------------------
// distinct_day_counter_core
// Counts distinct days of play for one configured game over a list of
// session records.
// ----------------------------------------------------------------------------
// One item at a time. An item without a counted record is taken in the
// idle state, which stays ready for the next. A last item passes through
// the emit state to queue its result. A counted record is accepted, waits
// for the day divide, then scans the days stored so far (up to TABLE_DEPTH)
// in the day table, reading one entry per cycle through its single read
// port, then goes to the insert state. A day already stored ends the scan
// early, without the insert. The result sits in an output register, so
// the next list may start while it waits. A second result stalls the
// input until the first one is taken. The table needs no clearing after
// reset.
// ----------------------------------------------------------------------------
module distinct_day_counter_core
    import ddc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [GAME_W-1:0]     i_cfg_wr_data,     // target_game
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,      // record_game, record_time
    input  logic                  s_axis_tuser,      // has_record
    input  logic                  s_axis_tlast,      // last_record
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DAYS_OUT_W-1:0] m_axis_tdata,      // distinct_days
    output logic                  m_axis_tuser       // table_overflow
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_state              r_state, n_state;
    logic [GAME_W-1:0]   r_target;
    logic                r_last;
    logic [CNT_W-1:0]    r_count;
    logic                r_ovf;
    logic [CNT_W-1:0]    r_addr;
    logic                r_pend;
    logic                r_out_valid;
    logic [DAYS_OUT_W-1:0] r_out_days;
    logic                r_out_ovf;

    logic                in_acc;
    logic                counted;
    logic                div_done;
    logic [DAY_W-1:0]    day;
    logic [DAY_W-1:0]    rdata;
    logic                issue;
    logic                hit;
    logic                full;
    logic                mem_we;
    logic                emit;
    logic [DAYS_OUT_W-1:0] n_days;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign counted = s_axis_tuser && !r_ovf && (s_axis_tdata[GAME_W-1:0] == r_target);
    assign issue   = r_addr < r_count;
    assign hit     = r_pend && (rdata == day);
    assign full    = r_count == CNT_W'(TABLE_DEPTH);
    assign n_days  = (32'(r_count) > 32'd255) ? '1 : DAYS_OUT_W'(r_count);

    ddc_day_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && counted),
        .i_time  (s_axis_tdata[63:32]),
        .o_done  (div_done),
        .o_day   (day)
    );

    ddc_day_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (day),
        .i_re    (r_state == S_SCAN && issue),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (counted) begin
                        n_state = S_DIV;
                    end else if (s_axis_tlast) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end else if (!issue && !r_pend) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        emit          = 1'b0;
        case (r_state)
            S_IDLE:   s_axis_tready = 1'b1;
            S_INSERT: mem_we        = !full;
            S_EMIT:   emit          = !r_out_valid || m_axis_tready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (r_state == S_SCAN) begin
                r_pend <= issue;
            end else begin
                r_pend <= 1'b0;
            end
            if (r_state == S_INSERT) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (emit) begin
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last <= s_axis_tlast;
        end
        if (r_state == S_SCAN) begin
            r_addr <= r_addr + CNT_W'(issue);
        end else begin
            r_addr <= '0;
        end
        if (emit) begin
            r_out_days <= r_ovf ? '0 : n_days;
            r_out_ovf  <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_days;
    assign m_axis_tuser  = r_out_ovf;

endmodule

// ===== sv/ddc_day_div.sv =====
// ----------------------------------------------------------------------------
// ddc_day_div
// Two-stage divide of a timestamp by the seconds of one day.
// ----------------------------------------------------------------------------
module ddc_day_div
    import ddc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_time,
    output logic              o_done,
    output logic [DAY_W-1:0]  o_day
);

    localparam int PROD_W = QUO_W + RECIP_W;

    logic                r_v1, r_v2;
    logic [QUO_W-1:0]    r_quo;
    logic [PROD_W-1:0]   r_prod;
    logic [DAY_W-1:0]    r_day;

    logic [DAY_W-1:0]    est;
    logic [QUO_W-1:0]    back;
    logic [QUO_W-1:0]    rem;
    logic [DAY_W-1:0]    n_day;

    // estimate is exact or one low
    always_comb begin
        est   = r_prod[PROD_W-1 -: DAY_W];
        back  = QUO_W'(est * DAY_ODD);
        rem   = r_quo - back;
        n_day = (rem >= QUO_W'(DAY_ODD)) ? est + DAY_W'(1) : est;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_time[TIME_W-1:DAY_SHIFT];
            r_prod <= PROD_W'(i_time[TIME_W-1:DAY_SHIFT] * DAY_RECIP);
        end
        if (r_v1) begin
            r_day <= n_day;
        end
    end

    assign o_done = r_v2;
    assign o_day  = r_day;

endmodule

// ===== sv/ddc_day_mem.sv =====
// ----------------------------------------------------------------------------
// ddc_day_mem
// Day table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ddc_day_mem
    import ddc_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [DAY_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [DAY_W-1:0] o_rdata
);

    logic [DAY_W-1:0] r_mem [DEPTH];
    logic [DAY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ddc_checker.sv =====
// ----------------------------------------------------------------------------
// ddc_checker
// Port-level checks for the distinct day counter.
// ----------------------------------------------------------------------------
module ddc_checker
    import ddc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [DAYS_OUT_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("overflow result carries a count");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken before list result was queued");

    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind distinct_day_counter_core ddc_checker u_ddc_checker (.*);
